// File: rtl/core/conv3x3_line_buffer_filter_defines.svh
// Assertion macros shared by the 3x3 line buffer filter RTL.
`ifndef CONV3X3_LINE_BUFFER_FILTER_DEFINES_SVH
`define CONV3X3_LINE_BUFFER_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks that an expression holds at every clock edge out of reset.
`define C3LB_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define C3LB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define C3LB_CHECK(label, expr, msg)
`define C3LB_CHECK_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/c3lb_pkg.sv
// Shared constants, types and widths of the 3x3 line buffer filter.
package c3lb_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int KERNEL_SIZE    = 3;
  localparam int COEF_FRAC_BITS = 12;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = COL_W + 1;
  localparam int QR_W       = $clog2(MAX_HEIGHT);
  localparam int EH_W       = QR_W + 1;
  localparam int ROW_CNT_W  = QR_W + 1;

  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ROW_W      = PROD_W + 2;
  localparam int SUM_W      = ROW_W + 2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * POS_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KERNEL_SIZE * COEF_W;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;
  typedef logic [CFG_DATA_W-1:0] coef_row_t;

  // Control that travels with each step of the window pipeline.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } res_meta_t;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    pix_t             pixel;
  } out_item_t;

endpackage

// File: rtl/core/c3lb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module c3lb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of an address written at the same edge returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/c3lb_window.sv
// Line store read-modify-write and the 3x3 window of recent columns.
module c3lb_window import c3lb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  pix_t             step_pix,
  input  logic [COL_W-1:0] step_col,
  input  res_meta_t        step_meta,
  output logic             win_valid,
  output win_t             win,
  output res_meta_t        win_meta
);

  // Upper holds the row above the current one, lower the row above that.
  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } col_pair_t;

  logic                 s1_valid;
  pix_t                 s1_pix;
  logic [COL_W-1:0]     s1_col;
  res_meta_t            s1_meta;
  logic                 s1_fwd;
  col_pair_t            s1_fwd_data;
  logic [2*PIX_W-1:0]   rd_raw;
  col_pair_t            rd_pair;
  col_pair_t            old_pair;
  col_pair_t            wr_pair;

  c3lb_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(wr_pair),
    .raddr(step_col),
    .rdata(rd_raw)
  );

  // The previous step writes the same column in the cycle this one reads it
  // when a row is one pixel wide, so its write data is forwarded.
  always_comb begin
    rd_pair  = col_pair_t'(rd_raw);
    old_pair = s1_fwd ? s1_fwd_data : rd_pair;
    wr_pair  = '{upper: s1_pix, lower: old_pair.upper};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_valid <= 1'b0;
    end else begin
      s1_valid  <= step;
      win_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix      <= step_pix;
    s1_col      <= step_col;
    s1_meta     <= step_meta;
    s1_fwd      <= s1_valid && (s1_col == step_col);
    s1_fwd_data <= wr_pair;
    if (s1_valid) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      win[0][KERNEL_SIZE-1] <= old_pair.lower;
      win[1][KERNEL_SIZE-1] <= old_pair.upper;
      win[2][KERNEL_SIZE-1] <= s1_pix;
      win_meta              <= s1_meta;
    end
  end

endmodule

// File: rtl/core/c3lb_mac.sv
// Masked multiply, row sums, final sum and saturation of the 3x3 window.
module c3lb_mac import c3lb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  win_t      win,
  input  res_meta_t in_meta,
  input  coef_row_t coef_top,
  input  coef_row_t coef_mid,
  input  coef_row_t coef_bot,
  output logic      res_valid,
  output pix_t      res_pixel,
  output res_meta_t res_meta
);

  coef_row_t                coef_rows [KERNEL_SIZE];
  logic [KERNEL_SIZE-1:0]   row_ok;
  logic [KERNEL_SIZE-1:0]   col_ok;
  logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [ROW_W-1:0]  row_sum_next [KERNEL_SIZE];
  logic signed [ROW_W-1:0]  row_sum [KERNEL_SIZE];
  logic signed [SUM_W-1:0]  total;
  logic                     prod_valid;
  logic                     sum_valid;
  res_meta_t                prod_meta;
  res_meta_t                sum_meta;

  function automatic logic signed [PROD_W-1:0] tap_mul(input pix_t px,
                                                       input logic signed [COEF_W-1:0] cf);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
    a = PROD_W'($signed({1'b0, px}));
    b = PROD_W'(cf);
    return a * b;
  endfunction

  assign coef_rows[0] = coef_top;
  assign coef_rows[1] = coef_mid;
  assign coef_rows[2] = coef_bot;
  assign row_ok = {in_meta.bot_ok, 1'b1, in_meta.top_ok};
  assign col_ok = {in_meta.right_ok, 1'b1, in_meta.left_ok};

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      row_sum_next[r] = '0;
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        row_sum_next[r] = row_sum_next[r] + ROW_W'(prod[r][c]);
      end
    end
    total = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      total = total + SUM_W'(row_sum[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid && in_meta.emit;
      sum_valid  <= prod_valid;
      res_valid  <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          prod[r][c] <= tap_mul(win[r][c], $signed(coef_rows[r][c*COEF_W +: COEF_W]));
        end else begin
          prod[r][c] <= '0;
        end
      end
    end
    prod_meta <= in_meta;
    row_sum   <= row_sum_next;
    sum_meta  <= prod_meta;
    res_meta  <= sum_meta;
    // Non-positive sums give zero; the rest drop the fraction and clip.
    if (total[SUM_W-1] || (total == '0)) begin
      res_pixel <= '0;
    end else if (|total[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      res_pixel <= PIX_MAX;
    end else begin
      res_pixel <= total[COEF_FRAC_BITS +: PIX_W];
    end
  end

endmodule

// File: rtl/core/c3lb_fifo.sv
// Small result queue in flip-flops between the arithmetic and the output.
module c3lb_fifo import c3lb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output out_item_t pop_item
);

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;

  assign pop_valid = (count != '0);
  assign pop_item  = mem[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/core/conv3x3_line_buffer_filter.sv
// Top level of the 3x3 zero-padded convolution filter with line buffers.
//
// The filter takes 8-bit grayscale pixels in raster order and returns each
// pixel convolved with a 3x3 kernel of signed Q4.12 coefficients, neighbours
// outside the frame counting as zero, the sum truncated toward zero and
// clipped to 0..255. A beat on the input carries either a pixel (tuser 0) or
// a drain request (tuser 1). A result leaves for every pixel beat once
// width+1 further pixels of the frame have arrived; after the last pixel of
// the frame each drain beat releases one of the remaining results, and the
// final result of the frame carries tlast. Pixels that arrive while a full
// frame still waits to be drained, early drains and surplus drains are
// consumed and produce nothing. The two previous rows live in a single 1024
// x 16-bit line RAM that every step reads and writes back in the next cycle,
// so the block takes one beat per clock while tready is high; each result
// is registered through the pipeline and queued in an eight-entry buffer,
// so output stalls reach the input only when results pending in the pipeline
// and that buffer fill it. A frame only one row high gets an inserted step
// after its last pixel, during which tready is low. The line RAM needs no
// clearing after reset, as entries from earlier frames are never used. The
// register port is always ready; writing the width or height restarts the
// frame, and registers must only be written while the filter is idle.
`include "conv3x3_line_buffer_filter_defines.svh"

module conv3x3_line_buffer_filter import c3lb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_value[7:0]
  input  logic [0:0]             s_axis_tuser,   // action[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_pixel[7:0], out_row[17:8], out_col[27:18]
  output logic                   m_axis_tlast,   // frame_last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_COEF_ROW_TOP    = 3'd2,
    REG_COEF_ROW_MIDDLE = 3'd3,
    REG_COEF_ROW_BOTTOM = 3'd4
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]      RST_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0]      RST_HEIGHT = DIM_W'(256);
  localparam logic [CFG_DATA_W-1:0] RST_COEF_OUTER = 48'h0100_0200_0100;
  localparam logic [CFG_DATA_W-1:0] RST_COEF_INNER = 48'h0200_0400_0200;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  coef_row_t        coef_row_top;
  coef_row_t        coef_row_middle;
  coef_row_t        coef_row_bottom;

  // Frame control: pr/pc is the raster position of the next window step,
  // qr/qc the position of the next result.
  logic [ROW_CNT_W-1:0]  pr;
  logic [COL_W-1:0]      pc;
  logic [QR_W-1:0]       qr;
  logic [COL_W-1:0]      qc;
  logic                  full;
  logic                  inj;
  logic [FIFO_CNT_W-1:0] reserved;

  logic [EW_W-1:0]  eff_w;
  logic [EH_W-1:0]  eff_h;
  logic [COL_W-1:0] w_max;
  logic [QR_W-1:0]  h_max;

  logic      in_fire;
  logic      out_fire;
  logic      cfg_fire;
  logic      is_drain;
  logic      pix_step;
  logic      drain_step;
  logic      step;
  logic      pos_emit;
  logic      emit_now;
  logic      last_now;
  logic      frame_px_done;
  res_meta_t step_meta;

  logic      win_valid;
  win_t      win;
  res_meta_t win_meta;
  logic      res_valid;
  pix_t      res_pixel;
  res_meta_t res_meta;
  out_item_t push_item;
  out_item_t pop_item;

  // Dimensions out of range are clamped where they are used.
  always_comb begin
    if (image_width == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = EH_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = EH_W'(MAX_HEIGHT);
    end else begin
      eff_h = EH_W'(image_height);
    end
    w_max = COL_W'(eff_w - EW_W'(1));
    h_max = QR_W'(eff_h - EH_W'(1));
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !inj && (reserved < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign is_drain      = s_axis_tuser[0];

  // Pixels count only until the frame is complete, drains only after it.
  // The inserted step covers the one raster position that a single-row
  // frame never receives before its first result is due.
  assign pix_step      = in_fire && !is_drain && !full;
  assign drain_step    = in_fire && is_drain && full;
  assign step          = pix_step || drain_step || inj;
  assign frame_px_done = (pc == w_max) && (pr == ROW_CNT_W'(h_max));

  // A pixel releases a result once width+1 pixels of the frame precede it.
  assign pos_emit = (pr > ROW_CNT_W'(1)) || ((pr == ROW_CNT_W'(1)) && (pc != '0));
  assign emit_now = drain_step || (pix_step && pos_emit);
  assign last_now = (qr == h_max) && (qc == w_max);

  always_comb begin
    step_meta.emit     = emit_now;
    step_meta.last     = last_now;
    step_meta.top_ok   = (qr != '0);
    step_meta.bot_ok   = (qr != h_max);
    step_meta.left_ok  = (qc != '0);
    step_meta.right_ok = (qc != w_max);
    step_meta.row      = POS_W'(qr);
    step_meta.col      = POS_W'(qc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_WIDTH;
      image_height    <= RST_HEIGHT;
      coef_row_top    <= RST_COEF_OUTER;
      coef_row_middle <= RST_COEF_INNER;
      coef_row_bottom <= RST_COEF_OUTER;
      pr              <= '0;
      pc              <= '0;
      qr              <= '0;
      qc              <= '0;
      full            <= 1'b0;
      inj             <= 1'b0;
      reserved        <= '0;
    end else begin
      if (step) begin
        if (pc == w_max) begin
          pc <= '0;
          pr <= pr + ROW_CNT_W'(1);
        end else begin
          pc <= pc + COL_W'(1);
        end
      end
      if (pix_step && frame_px_done) begin
        full <= 1'b1;
      end
      inj <= pix_step && frame_px_done && (h_max == '0);
      if (emit_now) begin
        if (last_now) begin
          pr   <= '0;
          pc   <= '0;
          qr   <= '0;
          qc   <= '0;
          full <= 1'b0;
        end else if (qc == w_max) begin
          qc <= '0;
          qr <= qr + QR_W'(1);
        end else begin
          qc <= qc + COL_W'(1);
        end
      end
      reserved <= reserved + FIFO_CNT_W'(emit_now) - FIFO_CNT_W'(out_fire);
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg_data[DIM_W-1:0];
            pr          <= '0;
            pc          <= '0;
            qr          <= '0;
            qc          <= '0;
            full        <= 1'b0;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[DIM_W-1:0];
            pr           <= '0;
            pc           <= '0;
            qr           <= '0;
            qc           <= '0;
            full         <= 1'b0;
          end
          REG_COEF_ROW_TOP:    coef_row_top    <= cfg_data;
          REG_COEF_ROW_MIDDLE: coef_row_middle <= cfg_data;
          REG_COEF_ROW_BOTTOM: coef_row_bottom <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  c3lb_window u_window (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .step_pix (s_axis_tdata[PIX_W-1:0]),
    .step_col (pc),
    .step_meta(step_meta),
    .win_valid(win_valid),
    .win      (win),
    .win_meta (win_meta)
  );

  c3lb_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (win_valid),
    .win      (win),
    .in_meta  (win_meta),
    .coef_top (coef_row_top),
    .coef_mid (coef_row_middle),
    .coef_bot (coef_row_bottom),
    .res_valid(res_valid),
    .res_pixel(res_pixel),
    .res_meta (res_meta)
  );

  always_comb begin
    push_item.last  = res_meta.last;
    push_item.col   = res_meta.col;
    push_item.row   = res_meta.row;
    push_item.pixel = res_pixel;
  end

  c3lb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_item(push_item),
    .pop_valid(m_axis_tvalid),
    .pop_ready(m_axis_tready),
    .pop_item (pop_item)
  );

  assign m_axis_tdata = {OUT_PAD_W'(0), pop_item.col, pop_item.row, pop_item.pixel};
  assign m_axis_tlast = pop_item.last;

  // Every queued result was reserved when its beat was accepted.
  `C3LB_CHECK(a_out_reserved, !m_axis_tvalid || (reserved != '0), "result queued without a reservation")

  // The step column never leaves the current row.
  `C3LB_CHECK(a_col_in_row, pc <= w_max, "step column beyond the frame width")

  // The last result of a frame starts the next frame afresh.
  `C3LB_CHECK_NEXT(a_frame_end, emit_now && last_now, (pr == '0) && (pc == '0) && !full, "frame not restarted after its last result")

endmodule
